// ----- sv/spsub_pkg.sv -----
package spsub_pkg;

  localparam int MAX_TERMS_DEF = 32;
  localparam int POW_W         = 16;
  localparam int COEF_W        = 16;
  localparam int OCOEF_W       = 17;

  localparam logic [1:0] OP_LOAD_A = 2'd0;
  localparam logic [1:0] OP_LOAD_B = 2'd1;
  localparam logic [1:0] OP_RUN    = 2'd2;

  typedef enum logic [1:0] {
    CMD_LOAD_A = 2'd0,
    CMD_LOAD_B = 2'd1,
    CMD_RUN    = 2'd2
  } cmd_kind_t;

  typedef struct packed {
    logic [POW_W-1:0]         power;
    logic signed [COEF_W-1:0] coef;
  } term_t;

  typedef struct packed {
    cmd_kind_t kind;
    term_t     term;
  } cmd_t;

endpackage

// ----- sv/spsub_if.sv -----
interface spsub_in_if;
  logic                                     valid;
  logic                                     ready;
  logic [1:0]                               opcode;
  logic [spsub_pkg::POW_W-1:0]              term_power;
  logic signed [spsub_pkg::COEF_W-1:0]      term_coef;

  modport source (output valid, output opcode, output term_power, output term_coef,
                  input ready);
  modport sink   (input valid, input opcode, input term_power, input term_coef,
                  output ready);
endinterface

interface spsub_out_if;
  logic                                     valid;
  logic                                     ready;
  logic [spsub_pkg::POW_W-1:0]              out_power;
  logic signed [spsub_pkg::OCOEF_W-1:0]     out_coef;
  logic                                     is_empty;
  logic                                     overflow;
  logic                                     last;

  modport source (output valid, output out_power, output out_coef, output is_empty,
                  output overflow, output last, input ready);
  modport sink   (input valid, input out_power, input out_coef, input is_empty,
                  input overflow, input last, output ready);
endinterface

// ----- sv/spsub_front.sv -----
module spsub_front (
  input  logic              clk,
  input  logic              rst_n,
  spsub_in_if.sink          in_ch,
  output spsub_pkg::cmd_t   cmd,
  output logic              cmd_valid,
  input  logic              cmd_ready
);
  import spsub_pkg::*;

  cmd_t       q_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       push, pop, known;
  cmd_t       cmd_in;

  always_comb begin
    known       = 1'b1;
    cmd_in.kind = CMD_RUN;
    cmd_in.term = '{power: in_ch.term_power, coef: in_ch.term_coef};
    unique case (in_ch.opcode)
      OP_LOAD_A: cmd_in.kind = CMD_LOAD_A;
      OP_LOAD_B: cmd_in.kind = CMD_LOAD_B;
      OP_RUN:    cmd_in.kind = CMD_RUN;
      default:   known = 1'b0;
    endcase
  end

  // An unused opcode is consumed here and never reaches the queue.
  assign in_ch.ready = (cnt_r != 2'd2);
  assign push        = in_ch.valid && in_ch.ready && known;
  assign cmd_valid   = (cnt_r != 2'd0);
  assign cmd         = q_r[rd_ptr_r];
  assign pop         = cmd_valid && cmd_ready;

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    case ({push, pop})
      2'b10:   cnt_nxt = cnt_r + 2'd1;
      2'b01:   cnt_nxt = cnt_r - 2'd1;
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= cmd_in;
    end
  end

endmodule

// ----- sv/spsub_back.sv -----
module spsub_back #(
  parameter int MAX_TERMS = spsub_pkg::MAX_TERMS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  spsub_pkg::cmd_t   cmd,
  input  logic              cmd_valid,
  output logic              cmd_ready,
  spsub_out_if.source       out_ch
);
  import spsub_pkg::*;

  localparam int CNT_W = $clog2(MAX_TERMS + 1);
  localparam int IDX_W = $clog2(MAX_TERMS);
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_TERMS);
  localparam logic [CNT_W-1:0] CNT_ONE = CNT_W'(1);

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_MERGE = 3'b010,
    S_FLUSH = 3'b100
  } bk_state_t;

  bk_state_t state_r, state_nxt;

  term_t store_a_r [MAX_TERMS];
  term_t store_b_r [MAX_TERMS];

  logic [CNT_W-1:0] cnt_a_r, cnt_a_nxt, cnt_b_r, cnt_b_nxt;
  logic [CNT_W-1:0] i_r, i_nxt, j_r, j_nxt;
  logic             drop_r, drop_nxt;
  logic             wr_a, wr_b;

  logic                      hold_v_r, hold_v_nxt;
  logic [POW_W-1:0]          hold_pow_r, hold_pow_nxt;
  logic signed [OCOEF_W-1:0] hold_coef_r, hold_coef_nxt;

  logic                      out_valid_r;
  logic [POW_W-1:0]          out_pow_r;
  logic signed [OCOEF_W-1:0] out_coef_r;
  logic                      out_empty_r, out_ovf_r, out_last_r;
  logic                      out_free;

  logic                      push, push_last, push_empty;
  logic [POW_W-1:0]          push_pow;
  logic signed [OCOEF_W-1:0] push_coef;

  term_t                     ta, tb;
  logic                      a_act, b_act, take_a, take_b;
  logic signed [OCOEF_W-1:0] ca_x, cb_x, new_coef;
  logic [POW_W-1:0]          new_pow;

  assign out_free  = !out_valid_r || out_ch.ready;
  assign cmd_ready = (state_r == S_IDLE);

  assign ta     = store_a_r[i_r[IDX_W-1:0]];
  assign tb     = store_b_r[j_r[IDX_W-1:0]];
  assign a_act  = (i_r < cnt_a_r);
  assign b_act  = (j_r < cnt_b_r);
  assign take_a = a_act && (!b_act || (ta.power < tb.power));
  assign take_b = b_act && (!a_act || (ta.power > tb.power));
  assign ca_x   = {ta.coef[COEF_W-1], ta.coef};
  assign cb_x   = {tb.coef[COEF_W-1], tb.coef};

  always_comb begin
    if (take_a) begin
      new_coef = ca_x;
      new_pow  = ta.power;
    end else if (take_b) begin
      new_coef = -cb_x;
      new_pow  = tb.power;
    end else begin
      new_coef = ca_x - cb_x;
      new_pow  = ta.power;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    cnt_a_nxt     = cnt_a_r;
    cnt_b_nxt     = cnt_b_r;
    i_nxt         = i_r;
    j_nxt         = j_r;
    drop_nxt      = drop_r;
    wr_a          = 1'b0;
    wr_b          = 1'b0;
    hold_v_nxt    = hold_v_r;
    hold_pow_nxt  = hold_pow_r;
    hold_coef_nxt = hold_coef_r;
    push          = 1'b0;
    push_last     = 1'b0;
    push_empty    = 1'b0;
    push_pow      = hold_pow_r;
    push_coef     = hold_coef_r;
    unique case (state_r)
      S_IDLE: begin
        if (cmd_valid) begin
          case (cmd.kind)
            CMD_LOAD_A: begin
              if (cnt_a_r < CNT_MAX) begin
                wr_a      = 1'b1;
                cnt_a_nxt = cnt_a_r + CNT_ONE;
              end else begin
                drop_nxt = 1'b1;
              end
            end
            CMD_LOAD_B: begin
              if (cnt_b_r < CNT_MAX) begin
                wr_b      = 1'b1;
                cnt_b_nxt = cnt_b_r + CNT_ONE;
              end else begin
                drop_nxt = 1'b1;
              end
            end
            CMD_RUN: begin
              i_nxt      = '0;
              j_nxt      = '0;
              hold_v_nxt = 1'b0;
              state_nxt  = S_MERGE;
            end
            default: ;
          endcase
        end
      end
      S_MERGE: begin
        if (out_free) begin
          if (!a_act && !b_act) begin
            state_nxt = S_FLUSH;
          end else begin
            if (!take_b) i_nxt = i_r + CNT_ONE;
            if (!take_a) j_nxt = j_r + CNT_ONE;
            // A term is held back one step so the final one can carry last.
            if (new_coef != '0) begin
              push          = hold_v_r;
              hold_v_nxt    = 1'b1;
              hold_pow_nxt  = new_pow;
              hold_coef_nxt = new_coef;
            end
          end
        end
      end
      S_FLUSH: begin
        if (out_free) begin
          push      = 1'b1;
          push_last = 1'b1;
          if (!hold_v_r) begin
            push_empty = 1'b1;
            push_pow   = '0;
            push_coef  = '0;
          end
          cnt_a_nxt  = '0;
          cnt_b_nxt  = '0;
          drop_nxt   = 1'b0;
          hold_v_nxt = 1'b0;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_a_r     <= '0;
      cnt_b_r     <= '0;
      i_r         <= '0;
      j_r         <= '0;
      drop_r      <= 1'b0;
      hold_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_a_r     <= cnt_a_nxt;
      cnt_b_r     <= cnt_b_nxt;
      i_r         <= i_nxt;
      j_r         <= j_nxt;
      drop_r      <= drop_nxt;
      hold_v_r    <= hold_v_nxt;
      out_valid_r <= push || (out_valid_r && !out_ch.ready);
    end
  end

  always_ff @(posedge clk) begin
    hold_pow_r  <= hold_pow_nxt;
    hold_coef_r <= hold_coef_nxt;
    if (wr_a) store_a_r[cnt_a_r[IDX_W-1:0]] <= cmd.term;
    if (wr_b) store_b_r[cnt_b_r[IDX_W-1:0]] <= cmd.term;
    if (push) begin
      out_pow_r   <= push_pow;
      out_coef_r  <= push_coef;
      out_empty_r <= push_empty;
      out_ovf_r   <= drop_r;
      out_last_r  <= push_last;
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.out_power = out_pow_r;
  assign out_ch.out_coef  = out_coef_r;
  assign out_ch.is_empty  = out_empty_r;
  assign out_ch.overflow  = out_ovf_r;
  assign out_ch.last      = out_last_r;

endmodule

// ----- sv/sparse_polynomial_subtract.sv -----
// Difference of two sparse polynomials, first minus second.
// The input channel takes commands: load a term of the first polynomial,
// load a term of the second, or run. Terms of each polynomial must be loaded
// in ascending power order, which the block does not check; loads beyond the
// store capacity are dropped and reported through the overflow bit of the
// next run's results. A load is written to its store as it leaves the
// two-entry command queue. A run makes one merge step per cycle while the
// output register is free, at most n1 + n2 steps, then a step that finds both
// stores spent and one that sends the final result, so the merge sets the
// throughput; each result passes the hold and output registers. The results
// come in ascending power order, one per transfer, and the final one of a
// run carries last; a run whose terms all cancel gives one empty marker.
// Commands that follow a run wait in the queue until its last result is in
// the output register. When the receiver stalls, the merge holds and the
// queue fills, after which input ready falls. Reset empties both stores,
// the queue and the output register.
module sparse_polynomial_subtract #(
  parameter int MAX_TERMS = spsub_pkg::MAX_TERMS_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  spsub_in_if.sink     in_ch,
  spsub_out_if.source  out_ch
);
  import spsub_pkg::*;

  cmd_t cmd;
  logic cmd_valid, cmd_ready;

  spsub_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .cmd       (cmd),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready)
  );

  spsub_back #(
    .MAX_TERMS (MAX_TERMS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .out_ch    (out_ch)
  );

  a_term_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.is_empty |-> out_ch.out_coef != '0)
    else $error("Term transfer with zero coefficient.");

  a_empty_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.is_empty |-> out_ch.last && out_ch.out_coef == '0)
    else $error("Empty marker without last or with a coefficient.");

  a_queue_drains_by_pop: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(cmd_valid) |-> $past(cmd_ready))
    else $error("Command queue emptied without a pop.");

endmodule
